/* rtl/kdc_pkg.sv */
// Shared types and constants for the key debounce and click classifier.
`timescale 1ns / 1ps

package kdc_pkg;

    localparam int NUM_KEYS_DEF = 4;
    localparam int LEVEL_W = 4;
    localparam int MASK_W = 4;
    localparam int CNT_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CNT_W-1:0] BOUNCE_TICKS_RST = 8'd10;
    localparam logic [CNT_W-1:0] LONG_TICKS_RST = 8'd50;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS = 1'b1;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_COLLECT = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [LEVEL_W-1:0] key_levels;
    } t_req;

    typedef struct packed {
        logic [MASK_W-1:0] clicked_mask;
        logic [MASK_W-1:0] long_clicked_mask;
    } t_rsp;

    typedef struct packed {
        logic short_flag;
        logic long_flag;
    } t_lane_flags;

endpackage

/* rtl/key_debounce_click_classifier_core.sv */
// Top level: key debounce and short/long click classifier.
//
//   channel   dir  handshake                 payload
//   in        in   i_in_valid / o_in_ready   i_in_data  (t_req)
//   out       out  o_out_valid / i_out_ready o_out_data (t_rsp)
//   cfg       in   i_cfg_we                  i_cfg_index, i_cfg_data
//
// One request per cycle while the queue has room: every key lane updates in
// the accept cycle and the merged masks are registered into a two-beat result
// queue, which presents them in order. Synchronous active-low reset clears
// phases, flags, queue and loads default tick thresholds. A stalled
// output holds ready low only once both queue entries are full.
`timescale 1ns / 1ps

module key_debounce_click_classifier_core import kdc_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_req                  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_rsp                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CNT_W-1:0]          r_bounce_ticks;
    logic [CNT_W-1:0]          r_long_ticks;
    logic                      accept;
    logic                      step;
    logic                      clear;
    t_lane_flags [NUM_KEYS-1:0] lane_flags;

    assign accept = i_in_valid && o_in_ready;
    assign step = accept && (i_in_data.req_type == REQ_TICK);
    assign clear = accept && (i_in_data.req_type == REQ_COLLECT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounce_ticks <= BOUNCE_TICKS_RST;
            r_long_ticks <= LONG_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BOUNCE_TICKS: r_bounce_ticks <= i_cfg_data[CNT_W-1:0];
                CFG_LONG_TICKS:   r_long_ticks <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        logic low;
        if (k < LEVEL_W) begin : g_pin
            assign low = !i_in_data.key_levels[k];
        end else begin : g_nopin
            assign low = 1'b0;
        end

        kdc_lane u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_step         (step),
            .i_clear        (clear),
            .i_low          (low),
            .i_bounce_ticks (r_bounce_ticks),
            .i_long_ticks   (r_long_ticks),
            .o_flags        (lane_flags[k])
        );
    end

    kdc_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_flags (lane_flags),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

/* rtl/kdc_lane.sv */
// Per-key debounce phase machine with held-time counter and click flags.
`timescale 1ns / 1ps

module kdc_lane import kdc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_clear,
    input  logic             i_low,
    input  logic [CNT_W-1:0] i_bounce_ticks,
    input  logic [CNT_W-1:0] i_long_ticks,
    output t_lane_flags      o_flags
);

    typedef enum logic [2:0] {
        PH_IDLE          = 3'd0,
        PH_PRESS_CHECK   = 3'd1,
        PH_PRESSED       = 3'd2,
        PH_RELEASE_CHECK = 3'd3,
        PH_RELEASED      = 3'd4
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_settle, n_settle;
    logic [CNT_W-1:0] r_held, n_held;
    logic             r_short, n_short;
    logic             r_long, n_long;
    logic [CNT_W-1:0] settle_inc;
    logic             settle_done;

    assign settle_inc = (r_settle == CNT_MAX) ? CNT_MAX : r_settle + 1'b1;
    assign settle_done = (settle_inc > i_bounce_ticks) || (settle_inc == CNT_MAX);

    always_comb begin
        n_phase = r_phase;
        n_settle = r_settle;
        n_held = r_held;
        n_short = r_short;
        n_long = r_long;
        if (i_step) begin
            unique case (r_phase)
                PH_PRESS_CHECK: begin
                    n_settle = settle_inc;
                    if (settle_done) begin
                        if (i_low) begin
                            n_phase = PH_PRESSED;
                            n_held = '0;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_PRESSED: begin
                    n_held = (r_held == CNT_MAX) ? CNT_MAX : r_held + 1'b1;
                    if (!i_low) begin
                        n_settle = '0;
                        n_phase = PH_RELEASE_CHECK;
                    end
                end
                PH_RELEASE_CHECK: begin
                    n_settle = settle_inc;
                    if (settle_done) begin
                        n_phase = i_low ? PH_PRESSED : PH_RELEASED;
                    end
                end
                PH_RELEASED: begin
                    if (r_held < i_long_ticks) begin
                        n_short = 1'b1;
                    end else begin
                        n_long = 1'b1;
                    end
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_low) begin
                        n_settle = '0;
                        n_phase = PH_PRESS_CHECK;
                    end
                end
            endcase
        end
    end

    assign o_flags.short_flag = n_short;
    assign o_flags.long_flag = n_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_short <= 1'b0;
            r_long <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_short <= i_clear ? 1'b0 : n_short;
            r_long <= i_clear ? 1'b0 : n_long;
        end
    end

    always_ff @(posedge i_clk) begin
        r_settle <= n_settle;
        r_held <= n_held;
    end

endmodule

/* rtl/kdc_merge.sv */
// Merges lane flags into result masks and queues result beats.
`timescale 1ns / 1ps

module kdc_merge import kdc_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_lane_flags [NUM_KEYS-1:0] i_flags,
    output logic                       o_ready,
    output logic                       o_valid,
    input  logic                       i_ready,
    output t_rsp                       o_data
);

    localparam int QDEPTH = 2;
    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    t_rsp              n_rsp;
    t_rsp              r_q [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              pop;

    always_comb begin
        n_rsp = '0;
        for (int k = 0; k < MASK_W; k++) begin
            if (k < NUM_KEYS) begin
                n_rsp.clicked_mask[k] = i_flags[k].short_flag;
                n_rsp.long_clicked_mask[k] = i_flags[k].long_flag;
            end
        end
    end

    assign o_ready = (r_count != CNT_QW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign pop = o_valid && i_ready;
    assign o_data = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= n_rsp;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_QW'(QDEPTH))
        else $error("result queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_QW'(QDEPTH)))
        else $error("push into full result queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("result queue count did not grow");

    a_empty_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_count == '0) |=> (o_valid && o_data == $past(n_rsp)))
        else $error("pushed beat not presented");

endmodule

/* bench/tb_key_debounce_click_classifier_core.sv */
// Testbench for the key debounce and click classifier: directed clicks, random key traffic.
`timescale 1ns / 1ps

module tb_key_debounce_click_classifier_core;
    import kdc_pkg::*;

    localparam int NUM_KEYS = NUM_KEYS_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        KS_IDLE          = 3'd0,
        KS_PRESS_CHECK   = 3'd1,
        KS_PRESSED       = 3'd2,
        KS_RELEASE_CHECK = 3'd3,
        KS_RELEASED      = 3'd4
    } t_model_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_req                  i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_rsp                  o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // debounce model state
    logic [CNT_W-1:0] bounce_cfg;
    logic [CNT_W-1:0] long_cfg;
    t_model_phase     model_phase [NUM_KEYS];
    logic [CNT_W-1:0] settle_cnt [NUM_KEYS];
    logic [CNT_W-1:0] held_cnt [NUM_KEYS];
    logic             short_pend [NUM_KEYS];
    logic             long_pend [NUM_KEYS];

    t_rsp mask_q [$];

    // random key traffic generator
    logic pin_level [NUM_KEYS];
    int   pin_run_left [NUM_KEYS];

    bit steady = 1'b0;
    int err_cnt = 0;
    int beats_in = 0;
    int beats_out = 0;
    int n_settings = 0;
    int short_total = 0;
    int long_total = 0;
    int cycles = 0;

    key_debounce_click_classifier_core #(
        .NUM_KEYS(NUM_KEYS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, mask_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end

    always @(negedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_out++;
            if (mask_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, o_out_data);
                err_cnt++;
            end else begin
                want = mask_q.pop_front();
                if (o_out_data.clicked_mask !== want.clicked_mask) begin
                    $display("%0t: clicked_mask expected %h actual %h",
                             $time, want.clicked_mask, o_out_data.clicked_mask);
                    err_cnt++;
                end
                if (o_out_data.long_clicked_mask !== want.long_clicked_mask) begin
                    $display("%0t: long_clicked_mask expected %h actual %h",
                             $time, want.long_clicked_mask, o_out_data.long_clicked_mask);
                    err_cnt++;
                end
            end
        end
    end

    function automatic bit settle_tick(int k);
        if (settle_cnt[k] != CNT_MAX) settle_cnt[k]++;
        return (settle_cnt[k] > bounce_cfg) || (settle_cnt[k] == CNT_MAX);
    endfunction

    task automatic predict_masks(input t_req r, output t_rsp o);
        logic low;
        o = '0;
        if (r.req_type == REQ_TICK) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                low = (k < LEVEL_W) ? ~r.key_levels[k] : 1'b0;
                case (model_phase[k])
                    KS_PRESS_CHECK: begin
                        if (settle_tick(k)) begin
                            if (low) begin
                                model_phase[k] = KS_PRESSED;
                                held_cnt[k] = '0;
                            end else begin
                                model_phase[k] = KS_IDLE;
                            end
                        end
                    end
                    KS_PRESSED: begin
                        if (held_cnt[k] != CNT_MAX) held_cnt[k]++;
                        if (!low) begin
                            settle_cnt[k] = '0;
                            model_phase[k] = KS_RELEASE_CHECK;
                        end
                    end
                    KS_RELEASE_CHECK: begin
                        if (settle_tick(k)) model_phase[k] = low ? KS_PRESSED : KS_RELEASED;
                    end
                    KS_RELEASED: begin
                        if (held_cnt[k] < long_cfg) short_pend[k] = 1'b1;
                        else long_pend[k] = 1'b1;
                        model_phase[k] = KS_IDLE;
                    end
                    default: begin
                        model_phase[k] = KS_IDLE;
                        if (low) begin
                            settle_cnt[k] = '0;
                            model_phase[k] = KS_PRESS_CHECK;
                        end
                    end
                endcase
            end
        end
        for (int k = 0; k < NUM_KEYS && k < MASK_W; k++) begin
            o.clicked_mask[k] = short_pend[k];
            o.long_clicked_mask[k] = long_pend[k];
        end
        if (r.req_type == REQ_COLLECT) begin
            short_total += $countones(o.clicked_mask);
            long_total += $countones(o.long_clicked_mask);
            for (int k = 0; k < NUM_KEYS; k++) begin
                short_pend[k] = 1'b0;
                long_pend[k] = 1'b0;
            end
        end
    endtask

    task automatic send_request(input t_req r);
        int gap;
        t_rsp o;
        gap = (!steady && $urandom_range(0, 99) < 33) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        predict_masks(r, o);
        mask_q.push_back(o);
        beats_in++;
    endtask

    task automatic send_tick(input logic [LEVEL_W-1:0] levels);
        t_req r;
        r.req_type = REQ_TICK;
        r.key_levels = levels;
        send_request(r);
    endtask

    task automatic send_collect(input logic [LEVEL_W-1:0] levels);
        t_req r;
        r.req_type = REQ_COLLECT;
        r.key_levels = levels;
        send_request(r);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (mask_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic apply_thresholds(input logic [CNT_W-1:0] b, input logic [CNT_W-1:0] l);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_BOUNCE_TICKS;
        i_cfg_data <= b;
        @(posedge i_clk);
        bounce_cfg = b;
        i_cfg_index <= CFG_LONG_TICKS;
        i_cfg_data <= l;
        @(posedge i_clk);
        long_cfg = l;
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic int pick_run_length();
        int sel;
        int b;
        int l;
        sel = $urandom_range(0, 99);
        b = int'(bounce_cfg);
        l = int'(long_cfg);
        if (sel < 15) return $urandom_range(1, 2);
        if (sel < 45) return b + $urandom_range(1, 4);
        if (sel < 70) return b + l + $urandom_range(0, 2);
        return b + l + $urandom_range(3, 300);
    endfunction

    task automatic run_random(input int n_items, input int pause_at);
        t_req r;
        for (int k = 0; k < NUM_KEYS; k++) pin_run_left[k] = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i == pause_at) hold_until_drained();
            if ($urandom_range(0, 99) < 10) begin
                r.req_type = REQ_COLLECT;
                r.key_levels = LEVEL_W'($urandom_range(0, 15));
            end else begin
                r.req_type = REQ_TICK;
                for (int k = 0; k < NUM_KEYS && k < LEVEL_W; k++) begin
                    if (pin_run_left[k] == 0) begin
                        pin_level[k] = ~pin_level[k];
                        pin_run_left[k] = pick_run_length();
                    end
                    r.key_levels[k] = pin_level[k];
                    pin_run_left[k]--;
                end
            end
            send_request(r);
        end
    endtask

    task automatic test_reset_thresholds();
        run_random(150, -1);
    endtask

    task automatic test_directed_clicks();
        hold_until_drained();
        apply_thresholds(8'd0, 8'd2);
        send_collect(4'b0000);
        send_tick(4'b1111);
        send_tick(4'b0000);
        send_tick(4'b1000);
        send_tick(4'b0001);
        send_tick(4'b0101);
        send_collect(4'b1111);
        send_tick(4'b1011);
        send_tick(4'b1111);
        send_tick(4'b1111);
        send_tick(4'b0000);
        send_collect(4'b0101);
        send_collect(4'b1010);
        send_tick(4'b0000);
        send_tick(4'b1111);
        send_tick(4'b1111);
        send_tick(4'b1111);
        send_tick(4'b0000);
        send_collect(4'b1111);
        hold_until_drained();
        apply_thresholds(8'd0, 8'd0);
        send_tick(4'b0000);
        send_tick(4'b0000);
        send_tick(4'b1111);
        send_tick(4'b1111);
        send_tick(4'b1111);
        send_collect(4'b0000);
    endtask

    task automatic test_threshold_sweep();
        hold_until_drained();
        apply_thresholds(BOUNCE_TICKS_RST, LONG_TICKS_RST);
        run_random(250, -1);
        hold_until_drained();
        apply_thresholds(8'd0, 8'd1);
        run_random(200, -1);
        hold_until_drained();
        apply_thresholds(8'd0, 8'd0);
        run_random(100, -1);
        hold_until_drained();
        apply_thresholds(8'd0, 8'd255);
        run_random(350, -1);
        hold_until_drained();
        apply_thresholds(8'd254, 8'd255);
        run_random(250, -1);
        hold_until_drained();
        apply_thresholds(8'd255, 8'd128);
        run_random(250, -1);
    endtask

    task automatic test_steady_stream();
        hold_until_drained();
        steady = 1'b1;
        apply_thresholds(8'd3, 8'd12);
        run_random(250, 125);
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        bounce_cfg = BOUNCE_TICKS_RST;
        long_cfg = LONG_TICKS_RST;
        for (int k = 0; k < NUM_KEYS; k++) begin
            model_phase[k] = KS_IDLE;
            settle_cnt[k] = '0;
            held_cnt[k] = '0;
            short_pend[k] = 1'b0;
            long_pend[k] = 1'b0;
            pin_level[k] = 1'b1;
            pin_run_left[k] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_thresholds();
        test_directed_clicks();
        test_threshold_sweep();
        test_steady_stream();

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        $display("Summary: %0d request beats, %0d result beats, %0d threshold settings",
                 beats_in, beats_out, n_settings);
        $display("Summary: %0d short and %0d long clicks collected", short_total, long_total);
        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/kdc_pkg.sv
rtl/kdc_lane.sv
rtl/kdc_merge.sv
rtl/key_debounce_click_classifier_core.sv
bench/tb_key_debounce_click_classifier_core.sv
